### src/dmc_pkg.sv
// Shared types and constants of the depth-first maze carver.
package dmc_pkg;

   // Payload widths of the request and response channels
   localparam int FUNC_W   = 1;
   localparam int DIR_W    = 2;
   localparam int ACTION_W = 3;
   localparam int CELL_W   = 6;

   // Configuration port
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_ROWS = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GRID_COLS = 1'd1;
   localparam logic [CSR_DATA_W-1:0] GRID_SIZE_RESET = 7'd8;

   // Width of the generation tag kept per visited-map entry
   localparam int EPOCH_W = 4;

   // Request function codes
   localparam logic [FUNC_W-1:0] FUNC_STEP  = 1'b0;
   localparam logic [FUNC_W-1:0] FUNC_START = 1'b1;

   // Move directions
   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   // Reported actions
   typedef enum logic [ACTION_W-1:0] {
      ACT_CARVED    = 3'd0,
      ACT_REJECTED  = 3'd1,
      ACT_BACKTRACK = 3'd2,
      ACT_FINISHED  = 3'd3,
      ACT_STARTED   = 3'd4
   } action_type;

endpackage

### src/dmc_req_if.sv
// Request channel of the maze carver: valid/ready plus function and direction.
interface dmc_req_if import dmc_pkg::*;;
   logic              valid;
   logic              ready;
   logic [FUNC_W-1:0] func;
   logic [DIR_W-1:0]  direction;

   modport source (output valid, output func, output direction, input ready);
   modport sink   (input valid, input func, input direction, output ready);
endinterface

### src/dmc_rsp_if.sv
// Response channel of the maze carver: valid/ready plus action and cell.
interface dmc_rsp_if import dmc_pkg::*;;
   logic              valid;
   logic              ready;
   action_type        action;
   logic [CELL_W-1:0] cell_row;
   logic [CELL_W-1:0] cell_col;
   logic [DIR_W-1:0]  carve_dir;

   modport source (output valid, output action, output cell_row, output cell_col,
                   output carve_dir, input ready);
   modport sink   (input valid, input action, input cell_row, input cell_col,
                   input carve_dir, output ready);
endinterface

### src/dfs_maze_carver.sv
// Top level of the depth-first (recursive backtracker) maze carver.
//
// Every request (start or step) passes ST_READY and then ST_EVAL: the transfer
// reads the stack entry below the top and the four neighbour tags, and ST_EVAL
// decides, writes back and loads the response register; a new request is taken
// once the block is back in ST_READY. The stack top lives in registers and the
// visited map is split by row parity into two banks of
// 2**(log2(MAX_ROWS)-1+log2(MAX_COLS)) entries (2048 at 64 x 64), each read at
// two addresses per cycle, so that all four neighbours come back together. Each
// map entry keeps a 4-bit generation tag; a start advances the generation, so
// clearing the map costs nothing, except that after reset and on every 15th
// start a clearing pass runs over both banks, one entry per bank per cycle,
// during which no request is taken. Configuration writes are taken at any time.
// A response waiting in the output register does not block the next request; it
// only holds the decision cycle of the one after.
module dfs_maze_carver import dmc_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   dmc_req_if.sink               req_ch,
   dmc_rsp_if.source             rsp_ch
);

   localparam int RW    = $clog2(MAX_ROWS);
   localparam int CW    = $clog2(MAX_COLS);
   localparam int BAW   = RW - 1 + CW;
   localparam int CELLS = MAX_ROWS * MAX_COLS;
   localparam int SAW   = $clog2(CELLS);
   localparam int CNTW  = $clog2(CELLS + 1);
   localparam int RSW   = $clog2(MAX_ROWS + 1);
   localparam int CSW   = $clog2(MAX_COLS + 1);
   localparam int SZA   = (RSW > CSW) ? RSW : CSW;
   localparam int SZW   = (SZA > CSR_DATA_W) ? SZA : CSR_DATA_W;
   localparam int STKW  = RW + CW;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_READY,
      ST_EVAL
   } state_type;

   // Registers
   state_type              state_ff,     state_in;
   logic [BAW-1:0]         clr_addr_ff,  clr_addr_in;
   logic                   origin_ff,    origin_in;
   logic [EPOCH_W-1:0]     epoch_ff,     epoch_in;
   logic [CNTW-1:0]        count_ff,     count_in;
   logic [RW-1:0]          top_row_ff,   top_row_in;
   logic [CW-1:0]          top_col_ff,   top_col_in;
   logic [CSR_DATA_W-1:0]  grid_rows_ff, grid_rows_in;
   logic [CSR_DATA_W-1:0]  grid_cols_ff, grid_cols_in;
   logic [FUNC_W-1:0]      func_ff,      func_in;
   logic [DIR_W-1:0]       dir_ff,       dir_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   action_type             rsp_act_ff,   rsp_act_in;
   logic [CELL_W-1:0]      rsp_row_ff,   rsp_row_in;
   logic [CELL_W-1:0]      rsp_col_ff,   rsp_col_in;
   logic [DIR_W-1:0]       rsp_dir_ff,   rsp_dir_in;

   // Stack memory
   logic [STKW-1:0]        stack_mem [CELLS];
   logic [STKW-1:0]        stk_rd_ff;
   logic                   stk_wr_en;
   logic [SAW-1:0]         stk_wr_addr;
   logic [STKW-1:0]        stk_wr_data;
   logic [SAW-1:0]         stk_rd_addr;

   // Visited banks
   logic                   req_fire;
   logic [BAW-1:0]         addr_up, addr_dn, addr_lf, addr_rt;
   logic [BAW-1:0]         b0_rd_a, b0_rd_b, b1_rd_a, b1_rd_b;
   logic [EPOCH_W-1:0]     b0_dat_a, b0_dat_b, b1_dat_a, b1_dat_b;
   logic                   b0_wr_en, b1_wr_en;
   logic [BAW-1:0]         b0_wr_addr, b1_wr_addr;
   logic [EPOCH_W-1:0]     b0_wr_data, b1_wr_data;

   // Neighbour evaluation
   logic                   row_par;
   logic [RW-1:0]          row_up, row_dn;
   logic [CW-1:0]          col_lf, col_rt;
   logic [SZW-1:0]         eff_rows, eff_cols;
   logic                   vis_up, vis_dn, vis_lf, vis_rt;
   logic [3:0]             open_dirs;
   logic [EPOCH_W-1:0]     next_epoch;
   logic [RW-1:0]          nb_row;
   logic [CW-1:0]          nb_col;
   logic [BAW-1:0]         nb_addr;
   logic                   nb_bank;
   logic                   out_free;

   assign req_fire = req_ch.valid && req_ch.ready;
   assign req_ch.ready = (state_ff == ST_READY);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // Neighbour coordinates and bank addresses of the top cell
   assign row_par = top_row_ff[0];
   assign row_up  = top_row_ff - RW'(1);
   assign row_dn  = top_row_ff + RW'(1);
   assign col_lf  = top_col_ff - CW'(1);
   assign col_rt  = top_col_ff + CW'(1);
   assign addr_up = (BAW'(row_up >> 1) << CW) | BAW'(top_col_ff);
   assign addr_dn = (BAW'(row_dn >> 1) << CW) | BAW'(top_col_ff);
   assign addr_lf = (BAW'(top_row_ff >> 1) << CW) | BAW'(col_lf);
   assign addr_rt = (BAW'(top_row_ff >> 1) << CW) | BAW'(col_rt);

   // Up/down sit in the opposite-parity bank, left/right in the own bank
   assign b0_rd_a = row_par ? addr_up : addr_lf;
   assign b0_rd_b = row_par ? addr_dn : addr_rt;
   assign b1_rd_a = row_par ? addr_lf : addr_up;
   assign b1_rd_b = row_par ? addr_rt : addr_dn;

   assign stk_rd_addr = SAW'(count_ff - CNTW'(2));

   dmc_visit_bank #(
      .ADDR_W (BAW),
      .DATA_W (EPOCH_W)
   ) u_bank0 (
      .clock     (clock),
      .rd_en     (req_fire),
      .rd_addr_a (b0_rd_a),
      .rd_addr_b (b0_rd_b),
      .rd_data_a (b0_dat_a),
      .rd_data_b (b0_dat_b),
      .wr_en     (b0_wr_en),
      .wr_addr   (b0_wr_addr),
      .wr_data   (b0_wr_data)
   );

   dmc_visit_bank #(
      .ADDR_W (BAW),
      .DATA_W (EPOCH_W)
   ) u_bank1 (
      .clock     (clock),
      .rd_en     (req_fire),
      .rd_addr_a (b1_rd_a),
      .rd_addr_b (b1_rd_b),
      .rd_data_a (b1_dat_a),
      .rd_data_b (b1_dat_b),
      .wr_en     (b1_wr_en),
      .wr_addr   (b1_wr_addr),
      .wr_data   (b1_wr_data)
   );

   // Stack memory: push on write, read the entry below the top on transfer
   always_ff @(posedge clock) begin
      if (stk_wr_en) begin
         stack_mem[stk_wr_addr] <= stk_wr_data;
      end
      if (req_fire) begin
         stk_rd_ff <= stack_mem[stk_rd_addr];
      end
   end

   // Effective grid size: zero acts as one, saturate at the maximum
   always_comb begin
      eff_rows = SZW'(grid_rows_ff);
      if (grid_rows_ff == '0) begin
         eff_rows = SZW'(1);
      end else if (SZW'(grid_rows_ff) > SZW'(MAX_ROWS)) begin
         eff_rows = SZW'(MAX_ROWS);
      end
      eff_cols = SZW'(grid_cols_ff);
      if (grid_cols_ff == '0) begin
         eff_cols = SZW'(1);
      end else if (SZW'(grid_cols_ff) > SZW'(MAX_COLS)) begin
         eff_cols = SZW'(MAX_COLS);
      end
   end

   // Visited when the tag matches the current generation
   assign vis_up = (row_par ? b0_dat_a : b1_dat_a) == epoch_ff;
   assign vis_dn = (row_par ? b0_dat_b : b1_dat_b) == epoch_ff;
   assign vis_lf = (row_par ? b1_dat_a : b0_dat_a) == epoch_ff;
   assign vis_rt = (row_par ? b1_dat_b : b0_dat_b) == epoch_ff;

   always_comb begin
      open_dirs = '0;
      open_dirs[DIR_UP]    = (top_row_ff != '0) && !vis_up;
      open_dirs[DIR_DOWN]  = ((SZW'(top_row_ff) + SZW'(1)) < eff_rows) && !vis_dn;
      open_dirs[DIR_LEFT]  = (top_col_ff != '0) && !vis_lf;
      open_dirs[DIR_RIGHT] = ((SZW'(top_col_ff) + SZW'(1)) < eff_cols) && !vis_rt;
   end

   // Cell and bank location of the neighbour in the requested direction
   always_comb begin
      nb_row  = top_row_ff;
      nb_col  = top_col_ff;
      nb_addr = addr_up;
      nb_bank = !row_par;
      case (dir_ff)
         DIR_UP: begin
            nb_row  = row_up;
            nb_addr = addr_up;
            nb_bank = !row_par;
         end
         DIR_DOWN: begin
            nb_row  = row_dn;
            nb_addr = addr_dn;
            nb_bank = !row_par;
         end
         DIR_LEFT: begin
            nb_col  = col_lf;
            nb_addr = addr_lf;
            nb_bank = row_par;
         end
         default: begin
            nb_col  = col_rt;
            nb_addr = addr_rt;
            nb_bank = row_par;
         end
      endcase
   end

   assign next_epoch = (epoch_ff == '1) ? EPOCH_W'(1) : epoch_ff + EPOCH_W'(1);

   // Next state, memory writes and response
   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      origin_in    = origin_ff;
      epoch_in     = epoch_ff;
      count_in     = count_ff;
      top_row_in   = top_row_ff;
      top_col_in   = top_col_ff;
      grid_rows_in = grid_rows_ff;
      grid_cols_in = grid_cols_ff;
      func_in      = func_ff;
      dir_in       = dir_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_act_in   = rsp_act_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_dir_in   = rsp_dir_ff;
      b0_wr_en     = 1'b0;
      b0_wr_addr   = nb_addr;
      b0_wr_data   = epoch_ff;
      b1_wr_en     = 1'b0;
      b1_wr_addr   = nb_addr;
      b1_wr_data   = epoch_ff;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = count_ff[SAW-1:0];
      stk_wr_data  = {nb_row, nb_col};

      // Configuration writes
      if (csr_wr_en) begin
         unique case (csr_index)
            REG_GRID_ROWS: grid_rows_in = csr_wdata;
            REG_GRID_COLS: grid_cols_in = csr_wdata;
            default: ;
         endcase
      end

      // Drop the response once transferred
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            // Sweep both banks; restore the origin mark after a generation wrap
            b0_wr_en   = 1'b1;
            b0_wr_addr = clr_addr_ff;
            b0_wr_data = (origin_ff && clr_addr_ff == '0) ? epoch_ff : '0;
            b1_wr_en   = 1'b1;
            b1_wr_addr = clr_addr_ff;
            b1_wr_data = '0;
            clr_addr_in = clr_addr_ff + BAW'(1);
            if (clr_addr_ff == '1) begin
               state_in  = ST_READY;
               origin_in = 1'b0;
            end
         end

         ST_READY: begin
            if (req_fire) begin
               func_in  = req_ch.func;
               dir_in   = req_ch.direction;
               state_in = ST_EVAL;
            end
         end

         ST_EVAL: begin
            if (out_free) begin
               state_in     = ST_READY;
               rsp_valid_in = 1'b1;
               rsp_row_in   = CELL_W'(top_row_ff);
               rsp_col_in   = CELL_W'(top_col_ff);
               rsp_dir_in   = DIR_UP;
               if (func_ff == FUNC_START) begin
                  // New generation, mark and push the origin
                  epoch_in    = next_epoch;
                  b0_wr_en    = 1'b1;
                  b0_wr_addr  = '0;
                  b0_wr_data  = next_epoch;
                  stk_wr_en   = 1'b1;
                  stk_wr_addr = '0;
                  stk_wr_data = '0;
                  count_in    = CNTW'(1);
                  top_row_in  = '0;
                  top_col_in  = '0;
                  rsp_act_in  = ACT_STARTED;
                  rsp_row_in  = '0;
                  rsp_col_in  = '0;
                  if (epoch_ff == '1) begin
                     state_in    = ST_CLEAR;
                     clr_addr_in = '0;
                     origin_in   = 1'b1;
                  end
               end else if (count_ff == '0) begin
                  rsp_act_in = ACT_FINISHED;
                  rsp_row_in = '0;
                  rsp_col_in = '0;
               end else if (open_dirs == '0) begin
                  // Dead end: pop, the entry below becomes the top
                  rsp_act_in = ACT_BACKTRACK;
                  count_in   = count_ff - CNTW'(1);
                  top_row_in = stk_rd_ff[STKW-1:CW];
                  top_col_in = stk_rd_ff[CW-1:0];
               end else if (open_dirs[dir_ff] && count_ff != CNTW'(CELLS)) begin
                  // Carve: mark and push the neighbour
                  rsp_act_in = ACT_CARVED;
                  rsp_dir_in = dir_ff;
                  b0_wr_en   = !nb_bank;
                  b1_wr_en   = nb_bank;
                  stk_wr_en  = 1'b1;
                  count_in   = count_ff + CNTW'(1);
                  top_row_in = nb_row;
                  top_col_in = nb_col;
               end else begin
                  rsp_act_in = ACT_REJECTED;
               end
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         origin_ff    <= 1'b0;
         epoch_ff     <= EPOCH_W'(1);
         count_ff     <= '0;
         grid_rows_ff <= GRID_SIZE_RESET;
         grid_cols_ff <= GRID_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         origin_ff    <= origin_in;
         epoch_ff     <= epoch_in;
         count_ff     <= count_in;
         grid_rows_ff <= grid_rows_in;
         grid_cols_ff <= grid_cols_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      top_row_ff <= top_row_in;
      top_col_ff <= top_col_in;
      func_ff    <= func_in;
      dir_ff     <= dir_in;
      rsp_act_ff <= rsp_act_in;
      rsp_row_ff <= rsp_row_in;
      rsp_col_ff <= rsp_col_in;
      rsp_dir_ff <= rsp_dir_in;
   end

   assign rsp_ch.valid     = rsp_valid_ff;
   assign rsp_ch.action    = rsp_act_ff;
   assign rsp_ch.cell_row  = rsp_row_ff;
   assign rsp_ch.cell_col  = rsp_col_ff;
   assign rsp_ch.carve_dir = rsp_dir_ff;

endmodule

### src/dmc_visit_bank.sv
// Visited-map bank: one write port, two registered read ports.
module dmc_visit_bank #(
   parameter int ADDR_W = 11,
   parameter int DATA_W = 4
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr_a,
   input  logic [ADDR_W-1:0] rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [2**ADDR_W];
   logic [DATA_W-1:0] rd_a_ff;
   logic [DATA_W-1:0] rd_b_ff;

   // Write the tag
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read both ports, hold data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

### sim/dmc_maze_checker.sv
// Checker for the maze carver: predicts every response from the observed transfers.
module dmc_maze_checker import dmc_pkg::*; #(
   parameter int MAX_ROWS = 64,
   parameter int MAX_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   dmc_req_if                    req_mon,
   dmc_rsp_if                    rsp_mon,
   output int                    fail_count,
   output int                    pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CELLS = MAX_ROWS * MAX_COLS;

   typedef struct packed {
      action_type        action;
      logic [CELL_W-1:0] row;
      logic [CELL_W-1:0] col;
      logic [DIR_W-1:0]  dir;
   } maze_event_type;

   // Shadow of the carver: visited cells, the path stack and the grid size
   logic                  visited [MAX_ROWS][MAX_COLS];
   logic [CELL_W-1:0]     trail_row [CELLS];
   logic [CELL_W-1:0]     trail_col [CELLS];
   logic [12:0]           trail_depth;
   logic [CSR_DATA_W-1:0] rows_cfg;
   logic [CSR_DATA_W-1:0] cols_cfg;

   maze_event_type awaited_events[$];
   maze_event_type want;
   maze_event_type seen;
   int             errors = 0;

   // A zero size acts as one, an oversized one saturates
   function automatic int usable_size(logic [CSR_DATA_W-1:0] raw, int limit);
      if (raw == 0) return 1;
      return (raw > limit) ? limit : int'(raw);
   endfunction

   // True when the neighbor in direction d is on the grid and not yet visited
   function automatic bit can_carve(int r, int c, logic [DIR_W-1:0] d, int nrows, int ncols,
                                    output int nr, output int nc);
      nr = r;
      nc = c;
      case (d)
         DIR_UP: begin
            if (r == 0) return 1'b0;
            nr = r - 1;
         end
         DIR_DOWN: begin
            if (r + 1 >= nrows) return 1'b0;
            nr = r + 1;
         end
         DIR_LEFT: begin
            if (c == 0) return 1'b0;
            nc = c - 1;
         end
         default: begin
            if (c + 1 >= ncols) return 1'b0;
            nc = c + 1;
         end
      endcase
      return !visited[nr][nc];
   endfunction

   // Advance the shadow maze by one request and give the response it causes
   function automatic maze_event_type carve_outcome(logic [FUNC_W-1:0] f,
                                                    logic [DIR_W-1:0] d);
      maze_event_type res;
      int             nrows, ncols, r, c, nr, nc, k;
      bit             any_open;
      nrows = usable_size(rows_cfg, MAX_ROWS);
      ncols = usable_size(cols_cfg, MAX_COLS);
      res.action = ACT_FINISHED;
      res.row = '0;
      res.col = '0;
      res.dir = '0;
      if (f == FUNC_START) begin
         foreach (visited[i, j]) visited[i][j] = 1'b0;
         visited[0][0] = 1'b1;
         trail_row[0] = '0;
         trail_col[0] = '0;
         trail_depth = 13'd1;
         res.action = ACT_STARTED;
         return res;
      end
      // empty stack: maze finished or never started
      if (trail_depth == 0) return res;
      r = trail_row[trail_depth - 1];
      c = trail_col[trail_depth - 1];
      res.row = CELL_W'(r);
      res.col = CELL_W'(c);
      any_open = 1'b0;
      for (k = 0; k < 4; k++)
         if (can_carve(r, c, DIR_W'(k), nrows, ncols, nr, nc)) any_open = 1'b1;
      // dead end: pop the top cell
      if (!any_open) begin
         trail_depth = trail_depth - 1'b1;
         res.action = ACT_BACKTRACK;
         return res;
      end
      if (can_carve(r, c, d, nrows, ncols, nr, nc) && trail_depth < CELLS) begin
         visited[nr][nc] = 1'b1;
         trail_row[trail_depth] = CELL_W'(nr);
         trail_col[trail_depth] = CELL_W'(nc);
         trail_depth = trail_depth + 1'b1;
         res.action = ACT_CARVED;
         res.dir = d;
         return res;
      end
      res.action = ACT_REJECTED;
      return res;
   endfunction

   function automatic void note_mismatch(string msg);
      errors++;
      if (errors <= 10) $display("%t mismatch: %s", $realtime, msg);
   endfunction

   // Track register writes, predict on each request transfer, compare on each response
   always @(posedge clock) begin
      if (reset) begin
         foreach (visited[i, j]) visited[i][j] = 1'b0;
         trail_depth = '0;
         rows_cfg = GRID_SIZE_RESET;
         cols_cfg = GRID_SIZE_RESET;
         awaited_events.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == REG_GRID_ROWS) rows_cfg = csr_wdata;
            else if (csr_index == REG_GRID_COLS) cols_cfg = csr_wdata;
         end
         if (req_mon.valid && req_mon.ready)
            awaited_events.push_back(carve_outcome(req_mon.func, req_mon.direction));
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.action = rsp_mon.action;
            seen.row = rsp_mon.cell_row;
            seen.col = rsp_mon.cell_col;
            seen.dir = rsp_mon.carve_dir;
            if (awaited_events.size() == 0) begin
               note_mismatch($sformatf("unexpected response action %0d cell (%0d,%0d) dir %0d",
                                       seen.action, seen.row, seen.col, seen.dir));
            end else begin
               want = awaited_events.pop_front();
               if (seen.action !== want.action || seen.row !== want.row ||
                   seen.col !== want.col || seen.dir !== want.dir)
                  note_mismatch($sformatf(
                     "expected action %0d cell (%0d,%0d) dir %0d, got action %0d cell (%0d,%0d) dir %0d",
                     want.action, want.row, want.col, want.dir,
                     seen.action, seen.row, seen.col, seen.dir));
            end
         end
      end
      pending <= awaited_events.size();
      fail_count <= errors;
   end

endmodule

### sim/tb.sv
// Top of the maze carver testbench: clock, reset, stimulus, response pacing and verdict.
module tb import dmc_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_ROWS      = 64;
   localparam int MAX_COLS      = 64;
   localparam int PHASE_ITEMS   = 500;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 8;

   typedef enum int {SHAPE_RANDOM, SHAPE_TALL, SHAPE_WIDE} shape_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = REG_GRID_ROWS;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int fail_count;
   int pending;
   int sent_count = 0;
   int send_idle_pct = 23;
   int recv_idle_pct = 66;
   bit hold_go = 1'b0;

   dmc_req_if req_ch ();
   dmc_rsp_if rsp_ch ();

   dfs_maze_carver #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   dmc_maze_checker #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) maze_check (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always #6 clock = ~clock;

   // Pace the response side; hold off once for a long stretch when asked
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_go && !hold_done) begin
            hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Offer one request, with random idle cycles first, and wait for its transfer
   task automatic send_req(input logic [FUNC_W-1:0] f, input logic [DIR_W-1:0] d);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.func      <= f;
      req_ch.direction <= d;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent_count++;
   endtask

   // Drop valid and wait until every response is back
   task automatic quiesce();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Write both size registers while the block is idle
   task automatic resize_grid(input logic [CSR_DATA_W-1:0] nrows,
                              input logic [CSR_DATA_W-1:0] ncols);
      quiesce();
      csr_wr_en <= 1'b1;
      csr_index <= REG_GRID_ROWS;
      csr_wdata <= nrows;
      @(posedge clock);
      csr_index <= REG_GRID_COLS;
      csr_wdata <= ncols;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One maze: pick a grid, start, then step with a biased random direction
   task automatic carve_episode(input shape_type shape, input bit press);
      logic [CSR_DATA_W-1:0] rows_raw, cols_raw;
      logic [DIR_W-1:0]      fav;
      int                    nrows, ncols, steps, bias, k, pick;
      pick = $urandom_range(99);
      fav = DIR_W'($urandom_range(3));
      bias = $urandom_range(50);
      case (shape)
         SHAPE_TALL: begin
            rows_raw = ($urandom_range(1)) ? CSR_DATA_W'(MAX_ROWS) : CSR_DATA_W'(127);
            cols_raw = CSR_DATA_W'($urandom_range(1));
            fav = DIR_DOWN;
            bias = 70;
         end
         SHAPE_WIDE: begin
            rows_raw = CSR_DATA_W'($urandom_range(1));
            cols_raw = ($urandom_range(1)) ? CSR_DATA_W'(MAX_COLS) : CSR_DATA_W'(127);
            fav = DIR_RIGHT;
            bias = 70;
         end
         default: begin
            if (pick < 75) begin
               rows_raw = CSR_DATA_W'($urandom_range(1, 6));
               cols_raw = CSR_DATA_W'($urandom_range(1, 6));
            end else if (pick < 90) begin
               rows_raw = CSR_DATA_W'($urandom_range(12));
               cols_raw = CSR_DATA_W'($urandom_range(12));
            end else begin
               rows_raw = CSR_DATA_W'($urandom_range(127));
               cols_raw = CSR_DATA_W'($urandom_range(127));
            end
         end
      endcase
      nrows = (rows_raw == 0) ? 1 : ((rows_raw > MAX_ROWS) ? MAX_ROWS : int'(rows_raw));
      ncols = (cols_raw == 0) ? 1 : ((cols_raw > MAX_COLS) ? MAX_COLS : int'(cols_raw));
      steps = 5 * nrows * ncols + 8;
      if (steps > 220) steps = 220;

      resize_grid(rows_raw, cols_raw);
      send_req(FUNC_START, DIR_W'($urandom_range(3)));
      for (k = 0; k < steps; k++) begin
         if (press && k == 1) hold_go <= 1'b1;
         // noise: restart in the middle, or resize the grid under the walk
         if ($urandom_range(99) < 2) begin
            send_req(FUNC_START, DIR_W'($urandom_range(3)));
         end else begin
            if (shape == SHAPE_RANDOM && $urandom_range(199) == 0)
               resize_grid(CSR_DATA_W'($urandom_range(9)), CSR_DATA_W'($urandom_range(9)));
            send_req(FUNC_STEP, ($urandom_range(99) < bias) ? fav : DIR_W'($urandom_range(3)));
         end
      end
   endtask

   initial begin
      int        phase, phase_start;
      shape_type first_shape;
      req_ch.valid = 1'b0;
      req_ch.func = FUNC_STEP;
      req_ch.direction = DIR_UP;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // steps before any start find an empty stack
      send_req(FUNC_STEP, DIR_UP);
      send_req(FUNC_STEP, DIR_RIGHT);
      // on the reset 8x8 grid: edge rejects, three carves, a visited reject
      send_req(FUNC_START, DIR_UP);
      send_req(FUNC_STEP, DIR_UP);
      send_req(FUNC_STEP, DIR_LEFT);
      send_req(FUNC_STEP, DIR_DOWN);
      send_req(FUNC_STEP, DIR_RIGHT);
      send_req(FUNC_STEP, DIR_UP);
      send_req(FUNC_STEP, DIR_LEFT);
      // shrink to zero sizes mid-maze: stacked cells fall outside, unwind to finished
      resize_grid('0, '0);
      send_req(FUNC_STEP, DIR_DOWN);
      send_req(FUNC_STEP, DIR_RIGHT);
      send_req(FUNC_STEP, DIR_UP);
      send_req(FUNC_STEP, DIR_LEFT);
      send_req(FUNC_STEP, DIR_DOWN);
      send_req(FUNC_START, DIR_RIGHT);
      send_req(FUNC_STEP, DIR_DOWN);
      send_req(FUNC_STEP, DIR_DOWN);
      // oversized rows saturate, columns at the maximum
      resize_grid(7'd127, CSR_DATA_W'(MAX_COLS));
      send_req(FUNC_START, DIR_LEFT);
      send_req(FUNC_STEP, DIR_DOWN);
      send_req(FUNC_STEP, DIR_RIGHT);
      send_req(FUNC_STEP, DIR_RIGHT);
      send_req(FUNC_STEP, DIR_UP);
      send_req(FUNC_STEP, DIR_LEFT);

      // random mazes under three pacing regimes
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 23;
               recv_idle_pct = 66;
               first_shape = SHAPE_TALL;
            end
            1: begin
               send_idle_pct = 66;
               recv_idle_pct = 23;
               first_shape = SHAPE_WIDE;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               first_shape = SHAPE_RANDOM;
            end
         endcase
         phase_start = sent_count;
         carve_episode(first_shape, phase == 2);
         while (sent_count - phase_start < PHASE_ITEMS) carve_episode(SHAPE_RANDOM, 1'b0);
      end

      quiesce();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) $display("tb OK");
      else $display("tb NOT OK");
      $finish;
   end

   // Hard stop in case the block hangs
   initial begin
      #10ms;
      $display("tb NOT OK");
      $finish;
   end

endmodule
